FILE: rtl/core/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, all clocked on clock and disabled in reset
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ukd_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// ukd_pkg
// types and constants shared by the unique key deque
//------------------------------------------------------------------------------
package ukd_pkg;

   localparam int DEPTH_DEFAULT     = 32;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int KEY_FIELD_WIDTH   = 32;

   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_FINISH     = 3'd4;

   localparam logic [1:0] STATUS_KEY   = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef struct packed {
      logic [2:0]                 mode;
      logic [KEY_FIELD_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_FIELD_WIDTH-1:0] key_out;
      logic [1:0]                 status;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic shift_r;
      logic shift_l;
      logic load;
      logic clear;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_STATUS
   } state_type;

endpackage

FILE: rtl/core/ukd_cell.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// ukd_cell
// one deque slot: key, valid bit and key match, shifts to either neighbor
//------------------------------------------------------------------------------
module ukd_cell #(
   parameter int KEY_WIDTH = ukd_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ukd_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_WIDTH-1:0]   new_key,
   input  logic [KEY_WIDTH-1:0]   prev_key,
   input  logic                   prev_valid,
   input  logic [KEY_WIDTH-1:0]   next_key,
   input  logic                   next_valid,
   output logic [KEY_WIDTH-1:0]   key,
   output logic                   valid,
   output logic                   match
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 valid_ff;
   logic                 valid_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift_r) begin
         key_in   = prev_key;
         valid_in = prev_valid;
      end else if (ctrl.shift_l) begin
         key_in   = next_key;
         valid_in = next_valid;
      end else if (ctrl.load) begin
         key_in   = new_key;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (key_ff == new_key);

endmodule

FILE: rtl/core/unique_key_deque.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// unique_key_deque
// bounded double-ended queue of distinct keys held in a row of shifting cells
//------------------------------------------------------------------------------
// channel  | ports              | direction | moves
// request  | req_valid/ready    | in        | mode and key, one per transfer
// response | rsp_valid/ready    | out       | key_out, status, last
//
// the front key always sits in cell 0; every cell compares its key in parallel
// push and pop take effect on their transfer; after its transfer a finish sends
// each held key in turn from the front (or a single status result)
// a response stall holds each result until it is taken
// reset clears all valid bits, the count and the error flag
// requests stall while a finish drains or sends its status result
//------------------------------------------------------------------------------
module unique_key_deque #(
   parameter int DEPTH     = ukd_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = ukd_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ukd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ukd_pkg::rsp_type rsp_data
);

   localparam int FW = ukd_pkg::KEY_FIELD_WIDTH;
   localparam int KW = (KEY_WIDTH < FW) ? KEY_WIDTH : FW;
   localparam int CW = $clog2(DEPTH + 1);

   ukd_pkg::state_type     state_ff;
   ukd_pkg::state_type     state_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   error_ff;
   logic                   error_in;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   ukd_pkg::rsp_type       rsp_data_ff;
   ukd_pkg::rsp_type       rsp_data_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   do_shift_r;
   logic                   do_shift_l;
   logic                   do_load_tail;
   logic                   do_drop_tail;
   logic                   do_clear_all;
   logic                   match_any;
   logic                   full;
   logic                   empty;
   logic [KW-1:0]          new_key;

   ukd_pkg::cell_ctrl_type cell_ctrl  [DEPTH];
   logic [KW-1:0]          cell_key   [DEPTH];
   logic [DEPTH-1:0]       cell_valid;
   logic [DEPTH-1:0]       cell_match;

   assign new_key   = req_data.key[KW-1:0];
   assign req_ready = (state_ff == ukd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign match_any = |cell_match;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KW-1:0] prev_key;
      logic          prev_valid;
      logic [KW-1:0] next_key;
      logic          next_valid;

      if (i == 0) begin : g_head
         assign prev_key   = new_key;
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_key   = cell_key[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_key   = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_key   = cell_key[i+1];
         assign next_valid = cell_valid[i+1];
      end

      assign cell_ctrl[i].shift_r = do_shift_r;
      assign cell_ctrl[i].shift_l = do_shift_l;
      assign cell_ctrl[i].load    = do_load_tail && (count_ff == CW'(i));
      assign cell_ctrl[i].clear   = do_clear_all ||
                                    (do_drop_tail && (count_ff == CW'(i + 1)));

      ukd_cell #(
         .KEY_WIDTH (KW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .new_key    (new_key),
         .prev_key   (prev_key),
         .prev_valid (prev_valid),
         .next_key   (next_key),
         .next_valid (next_valid),
         .key        (cell_key[i]),
         .valid      (cell_valid[i]),
         .match      (cell_match[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      status_in    = status_ff;
      do_shift_r   = 1'b0;
      do_shift_l   = 1'b0;
      do_load_tail = 1'b0;
      do_drop_tail = 1'b0;
      do_clear_all = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ukd_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  ukd_pkg::MODE_PUSH_FRONT, ukd_pkg::MODE_PUSH_BACK: begin
                     if (!error_ff) begin
                        if (full || match_any) begin
                           error_in = 1'b1;
                        end else begin
                           do_shift_r   = (req_data.mode == ukd_pkg::MODE_PUSH_FRONT);
                           do_load_tail = (req_data.mode == ukd_pkg::MODE_PUSH_BACK);
                           count_in     = count_ff + CW'(1);
                        end
                     end
                  end
                  ukd_pkg::MODE_POP_FRONT, ukd_pkg::MODE_POP_BACK: begin
                     if (!error_ff) begin
                        if (empty) begin
                           error_in = 1'b1;
                        end else begin
                           do_shift_l   = (req_data.mode == ukd_pkg::MODE_POP_FRONT);
                           do_drop_tail = (req_data.mode == ukd_pkg::MODE_POP_BACK);
                           count_in     = count_ff - CW'(1);
                        end
                     end
                  end
                  ukd_pkg::MODE_FINISH: begin
                     if (error_ff || empty) begin
                        status_in    = error_ff ? ukd_pkg::STATUS_ERROR
                                                : ukd_pkg::STATUS_EMPTY;
                        do_clear_all = 1'b1;
                        count_in     = '0;
                        error_in     = 1'b0;
                        state_in     = ukd_pkg::ST_STATUS;
                     end else begin
                        state_in = ukd_pkg::ST_DRAIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ukd_pkg::ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.key_out = FW'(cell_key[0]);
               rsp_data_in.status  = ukd_pkg::STATUS_KEY;
               rsp_data_in.last    = (count_ff == CW'(1));
               do_shift_l          = 1'b1;
               count_in            = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = ukd_pkg::ST_IDLE;
               end
            end
         end
         ukd_pkg::ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.key_out = '0;
               rsp_data_in.status  = status_ff;
               rsp_data_in.last    = 1'b1;
               state_in            = ukd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ukd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ukd_pkg::ST_IDLE;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/ukd_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// ukd_checker
// port-level checks on the unique key deque, bound to the top level
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module ukd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ukd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ukd_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   `ASSERT_SAME(a_status_code, rsp_valid, rsp_data.status == ukd_pkg::STATUS_KEY || rsp_data.status == ukd_pkg::STATUS_EMPTY || rsp_data.status == ukd_pkg::STATUS_ERROR, "undefined status code")
   `ASSERT_SAME(a_status_alone, rsp_valid && rsp_data.status != ukd_pkg::STATUS_KEY, rsp_data.last && rsp_data.key_out == '0, "status result not a lone zero result")
   `ASSERT_NEXT(a_drain_runs, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid, "drain gap after non-last transfer")

endmodule

bind unique_key_deque ukd_checker u_ukd_checker (.*);
